### design/slot_table_with_free_list_assert.svh
// Assertion macros for the slot table with free list.
// Used by design files that check their own state; assumes clk and rst in scope.
`ifndef SLOT_TABLE_WITH_FREE_LIST_ASSERT_SVH
`define SLOT_TABLE_WITH_FREE_LIST_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define STF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define STF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/stf_pkg.sv
// Shared types and constants for the slot table with free list.
// No dependencies; compiled before every other design file.
package stf_pkg;

  localparam int SLOTS  = 256;
  localparam int IDX_W  = 8;
  localparam int CNT_W  = 9;
  localparam int VAL_W  = 32;
  localparam int SIZE_W = 3;

  typedef logic [IDX_W-1:0]  stf_idx_t;
  typedef logic [CNT_W-1:0]  stf_cnt_t;
  typedef logic [VAL_W-1:0]  stf_val_t;
  typedef logic [SIZE_W-1:0] stf_size_t;

  // Table entry: occupancy flag above the stored word
  typedef logic [VAL_W:0]    stf_ent_t;

  // Byte size of a value entry
  localparam stf_size_t ENTRY_BYTES = 3'd4;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_GET    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_SIZE   = 2'd3
  } stf_mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FREE      = 2'd2,
    ST_FULL      = 2'd3
  } stf_status_t;

endpackage

### design/stf_if.sv
// Valid/ready channel interfaces for request and response items.
// Depends on stf_pkg for the payload types.
interface stf_req_if;
  import stf_pkg::*;

  logic      valid;
  logic      ready;
  stf_mode_t mode;
  stf_idx_t  slot_index;
  stf_val_t  push_value;

  modport source (output valid, output mode, output slot_index, output push_value,
                  input ready);
  modport sink   (input valid, input mode, input slot_index, input push_value,
                  output ready);
endinterface

interface stf_rsp_if;
  import stf_pkg::*;

  logic        valid;
  logic        ready;
  stf_status_t status;
  stf_idx_t    result_slot;
  stf_val_t    read_value;
  stf_size_t   entry_size;
  stf_cnt_t    used_count;

  modport source (output valid, output status, output result_slot, output read_value,
                  output entry_size, output used_count, input ready);
  modport sink   (input valid, input status, input result_slot, input read_value,
                  input entry_size, input used_count, output ready);
endinterface

### design/stf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents when read and write hit the same address.
module stf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, hold data when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/slot_table_with_free_list.sv
// Top level of the slot table with free list.
// Depends on stf_pkg, stf_if, stf_ram and the assertion macro header.
`include "slot_table_with_free_list_assert.svh"

// The block accepts one item per clock while the response side takes its
// results, and returns one result item for each. An accepted item first
// sits in an input register while its reads of the entry RAM and the
// free-stack RAM complete; the operation is then resolved combinationally
// as the item moves into the result register. A result waiting
// on the response side does not block acceptance until the input register is
// also full. The stack top and the addressed entry are forwarded when the item
// ahead writes the same RAM entry. No clearing pass follows reset: each entry
// holds an occupancy flag beside its word, an entry is only consulted below
// the high-water mark, and every slot there was written when first handed out.
module slot_table_with_free_list (
  input  logic      clk,
  input  logic      rst,
  stf_req_if.sink   req,
  stf_rsp_if.source rsp
);
  import stf_pkg::*;

  // Input register
  logic      s1_valid;
  stf_mode_t s1_mode;
  stf_idx_t  s1_idx;
  stf_val_t  s1_value;

  // Forwarding from a write that coincided with the read
  logic     val_fwd_hit;
  stf_ent_t val_fwd_data;
  logic     stk_fwd_hit;
  stf_idx_t stk_fwd_slot;

  // Table state
  stf_cnt_t free_depth;
  stf_cnt_t free_depth_next;
  stf_cnt_t high_water;
  stf_cnt_t high_water_next;

  // Handshake
  logic advance;
  logic accept;

  // RAM ports
  stf_ent_t val_rdata;
  stf_ent_t val_wdata;
  stf_idx_t stk_rdata;
  stf_idx_t stk_raddr;
  logic     val_we_q;
  logic     stk_we_q;

  // Operation results
  stf_status_t res_status;
  stf_idx_t    res_slot;
  stf_val_t    res_value;
  stf_size_t   res_size;
  stf_cnt_t    depth_calc;
  stf_cnt_t    hw_calc;
  logic        val_we;
  logic        stk_we;
  logic        occ_set;
  logic        occ_clr;
  stf_idx_t    top_slot;
  stf_ent_t    cur_entry;
  stf_val_t    cur_value;
  logic        in_range;
  logic        cur_occ;

  // Move the item on when the result register is free or being drained
  assign advance   = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign accept    = req.valid && req.ready;

  // Load the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode  <= req.mode;
      s1_idx   <= req.slot_index;
      s1_value <= req.push_value;
    end
  end

  // Resolve the operation of the item in the input register
  assign top_slot  = stk_fwd_hit ? stk_fwd_slot : stk_rdata;
  assign cur_entry = val_fwd_hit ? val_fwd_data : val_rdata;
  assign cur_value = cur_entry[VAL_W-1:0];
  assign cur_occ   = cur_entry[VAL_W];
  assign in_range  = {1'b0, s1_idx} < high_water;

  always_comb begin
    res_status = ST_OK;
    res_slot   = s1_idx;
    res_value  = '0;
    res_size   = '0;
    depth_calc = free_depth;
    hw_calc    = high_water;
    val_we     = 1'b0;
    stk_we     = 1'b0;
    occ_set    = 1'b0;
    occ_clr    = 1'b0;
    case (s1_mode)
      MODE_PUSH: begin
        if (free_depth != '0) begin
          depth_calc = free_depth - CNT_W'(1);
          res_slot   = top_slot;
          val_we     = 1'b1;
          occ_set    = 1'b1;
        end else if (high_water < CNT_W'(SLOTS)) begin
          res_slot = high_water[IDX_W-1:0];
          hw_calc  = high_water + CNT_W'(1);
          val_we   = 1'b1;
          occ_set  = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      MODE_GET: begin
        if (!in_range) begin
          res_status = ST_BAD_INDEX;
        end else if (cur_occ) begin
          res_value = cur_value;
        end else begin
          res_status = ST_FREE;
        end
      end
      MODE_REMOVE: begin
        if (!in_range) begin
          res_status = ST_BAD_INDEX;
        end else if (!cur_occ || free_depth >= CNT_W'(SLOTS)) begin
          res_status = ST_FREE;
        end else begin
          val_we     = 1'b1;
          stk_we     = 1'b1;
          occ_clr    = 1'b1;
          depth_calc = free_depth + CNT_W'(1);
        end
      end
      MODE_SIZE: begin
        if (!in_range) begin
          res_status = ST_BAD_INDEX;
        end else begin
          res_size = cur_occ ? ENTRY_BYTES : '0;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // Commit state only when the item moves on
  assign val_we_q        = advance && val_we;
  assign val_wdata       = {occ_set, s1_value};
  assign stk_we_q        = advance && stk_we;
  assign free_depth_next = advance ? depth_calc : free_depth;
  assign high_water_next = advance ? hw_calc : high_water;
  assign stk_raddr       = free_depth_next[IDX_W-1:0] - IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      free_depth <= '0;
      high_water <= '0;
    end else begin
      free_depth <= free_depth_next;
      high_water <= high_water_next;
    end
  end

  // Capture a write that lands on the entry being read this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      val_fwd_hit <= 1'b0;
      stk_fwd_hit <= 1'b0;
    end else if (accept) begin
      val_fwd_hit <= val_we_q && (res_slot == req.slot_index);
      stk_fwd_hit <= stk_we_q && (free_depth[IDX_W-1:0] == stk_raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val_fwd_data <= val_wdata;
      stk_fwd_slot <= s1_idx;
    end
  end

  // Slot entry store: occupancy flag and value
  stf_ram #(
    .WIDTH (VAL_W + 1),
    .DEPTH (SLOTS)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we_q),
    .waddr (res_slot),
    .wdata (val_wdata),
    .re    (accept),
    .raddr (req.slot_index),
    .rdata (val_rdata)
  );

  // Free slot stack
  stf_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOTS)
  ) u_stk_ram (
    .clk   (clk),
    .we    (stk_we_q),
    .waddr (free_depth[IDX_W-1:0]),
    .wdata (s1_idx),
    .re    (accept),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.status      <= res_status;
      rsp.result_slot <= res_slot;
      rsp.read_value  <= res_value;
      rsp.entry_size  <= res_size;
      rsp.used_count  <= hw_calc;
    end
  end

  // Checks
  `STF_ASSERT_SAME(a_depth_le_hw, 1'b1, free_depth <= high_water, "free depth above high water")
  `STF_ASSERT_SAME(a_hw_le_slots, 1'b1, high_water <= CNT_W'(SLOTS), "high water beyond table")
  `STF_ASSERT_SAME(a_push_below_hw, advance && occ_set, CNT_W'(res_slot) < high_water_next, "push slot beyond high water")
  `STF_ASSERT_NEXT(a_remove_grows, advance && occ_clr, free_depth == $past(free_depth) + CNT_W'(1), "remove did not push slot")

endmodule

### bench/tb.sv
// Testbench for slot_table_with_free_list: directed and random request items,
// each result checked against a behavioral model of the table and free stack.
// Depends on stf_pkg, the stf_req_if/stf_rsp_if interfaces and the design files.
`timescale 1ns / 100ps

module tb;
  import stf_pkg::*;

  typedef struct {
    stf_status_t status;
    stf_idx_t    slot;
    stf_val_t    value;
    stf_size_t   size;
    stf_cnt_t    used;
  } rsp_item_t;

  logic clk;
  logic rst;

  stf_req_if req();
  stf_rsp_if rsp();

  slot_table_with_free_list u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Model of the table: values, occupancy, LIFO of freed slots, high-water mark
  stf_val_t  tbl_value [SLOTS];
  bit        tbl_busy  [SLOTS];
  stf_idx_t  free_lifo [SLOTS];
  int        lifo_depth = 0;
  int        hwm = 0;

  rsp_item_t rsp_due[$];
  int        errors = 0;
  int        req_gap_max = 19;
  int        rsp_gap_max = 19;
  int        hold_cycles = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Compute the result of one operation and advance the table model
  function automatic rsp_item_t predict_table_op(stf_mode_t m, stf_idx_t idx, stf_val_t v);
    rsp_item_t r;
    int        slot;
    r.status = ST_OK;
    r.slot   = idx;
    r.value  = '0;
    r.size   = '0;
    if (m == MODE_PUSH) begin
      slot = -1;
      if (lifo_depth > 0) begin
        lifo_depth--;
        slot = free_lifo[lifo_depth];
      end else if (hwm < SLOTS) begin
        slot = hwm;
        hwm++;
      end
      if (slot < 0) begin
        r.status = ST_FULL;
      end else begin
        tbl_value[slot] = v;
        tbl_busy[slot]  = 1'b1;
        r.slot          = stf_idx_t'(slot);
      end
    end else if (int'(idx) >= hwm) begin
      r.status = ST_BAD_INDEX;
    end else begin
      case (m)
        MODE_GET: begin
          if (tbl_busy[idx]) r.value = tbl_value[idx];
          else r.status = ST_FREE;
        end
        MODE_REMOVE: begin
          if (!tbl_busy[idx]) begin
            r.status = ST_FREE;
          end else begin
            tbl_busy[idx]         = 1'b0;
            free_lifo[lifo_depth] = idx;
            lifo_depth++;
          end
        end
        default: begin
          r.size = tbl_busy[idx] ? ENTRY_BYTES : '0;
        end
      endcase
    end
    r.used = stf_cnt_t'(hwm);
    return r;
  endfunction

  // Mostly address slots below the high-water mark, sometimes anywhere
  function automatic stf_idx_t pick_index();
    if (hwm == 0 || $urandom_range(0, 7) == 0) return stf_idx_t'($urandom_range(0, 255));
    return stf_idx_t'($urandom_range(0, hwm - 1));
  endfunction

  // Offer one request item after a random gap; record its expected result on accept
  task automatic send_item(input stf_mode_t m, input stf_idx_t idx, input stf_val_t v);
    int gap;
    gap = $urandom_range(0, req_gap_max);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid      <= 1'b1;
    req.mode       <= m;
    req.slot_index <= idx;
    req.push_value <= v;
    do @(posedge clk); while (req.ready !== 1'b1);
    rsp_due.push_back(predict_table_op(m, idx, v));
    @(negedge clk);
  endtask

  // Hold the sender until every expected result has arrived
  task automatic wait_drain();
    req.valid <= 1'b0;
    @(negedge clk);
    while (rsp_due.size() != 0) @(negedge clk);
  endtask

  // Send a weighted random mix of operations
  task automatic run_mix(input int count, input int w_push, input int w_get,
                         input int w_rem);
    int        pick;
    stf_mode_t m;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < w_push) m = MODE_PUSH;
      else if (pick < w_push + w_get) m = MODE_GET;
      else if (pick < w_push + w_get + w_rem) m = MODE_REMOVE;
      else m = MODE_SIZE;
      send_item(m, pick_index(), $urandom());
    end
  endtask

  // Empty table, field extremes, slot reuse in LIFO order
  task automatic test_directed();
    send_item(MODE_GET,    8'd0,   32'h1234_5678);
    send_item(MODE_REMOVE, 8'd0,   32'h0);
    send_item(MODE_SIZE,   8'd255, 32'hFFFF_FFFF);
    send_item(MODE_PUSH,   8'hAA,  32'h0000_0000);
    send_item(MODE_PUSH,   8'h55,  32'hFFFF_FFFF);
    send_item(MODE_PUSH,   8'd255, 32'hA5A5_A5A5);
    send_item(MODE_GET,    8'd0,   32'h0);
    send_item(MODE_GET,    8'd1,   32'h0);
    send_item(MODE_SIZE,   8'd1,   32'h0);
    send_item(MODE_GET,    8'd3,   32'h0);
    send_item(MODE_GET,    8'd255, 32'h0);
    send_item(MODE_REMOVE, 8'd1,   32'h0);
    send_item(MODE_REMOVE, 8'd1,   32'h0);
    send_item(MODE_GET,    8'd1,   32'h0);
    send_item(MODE_SIZE,   8'd1,   32'h0);
    send_item(MODE_PUSH,   8'd0,   32'h5A5A_5A5A);
    send_item(MODE_GET,    8'd1,   32'h0);
    send_item(MODE_REMOVE, 8'd2,   32'h0);
    send_item(MODE_REMOVE, 8'd0,   32'h0);
    send_item(MODE_PUSH,   8'd7,   32'hDEAD_BEEF);
    send_item(MODE_PUSH,   8'd9,   32'h0BAD_F00D);
    send_item(MODE_PUSH,   8'd4,   32'h8000_0001);
    send_item(MODE_GET,    8'd0,   32'h0);
    wait_drain();
  endtask

  // Random traffic on a partly filled table, then a stretch with no idling
  task automatic test_random_partial();
    run_mix(500, 35, 25, 25);
    req_gap_max = 0;
    rsp_gap_max = 0;
    run_mix(150, 35, 25, 25);
    req_gap_max = 19;
    rsp_gap_max = 19;
  endtask

  // Stall the response side long enough to back up the input, then drain
  task automatic test_backpressure();
    req_gap_max = 0;
    hold_cycles = 300;
    run_mix(40, 40, 30, 20);
    req_gap_max = 19;
    wait_drain();
  endtask

  // Push until every slot is handed out, then a few pushes that find it full
  task automatic test_fill_table();
    while (!(hwm == SLOTS && lifo_depth == 0))
      send_item(MODE_PUSH, pick_index(), $urandom());
    repeat (6) send_item(MODE_PUSH, stf_idx_t'($urandom_range(0, 255)), $urandom());
  endtask

  // Churn a full table: removes refill the stack, pushes drain it or see full
  task automatic test_full_churn();
    run_mix(250, 40, 20, 30);
    req_gap_max = 0;
    rsp_gap_max = 0;
    run_mix(150, 40, 20, 30);
    req_gap_max = 19;
    rsp_gap_max = 19;
    run_mix(100, 40, 20, 30);
  endtask

  // Response side: random ready gaps, plus a long hold when asked
  initial begin
    int n;
    rsp.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles != 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = $urandom_range(0, rsp_gap_max);
      end
      if (n != 0) begin
        rsp.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!(rsp.valid === 1'b1 && rsp.ready === 1'b1));
      @(negedge clk);
    end
  end

  // Compare each accepted result item with the oldest expectation
  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (rsp_due.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual status %0d slot %0d",
                 $time, rsp.status, rsp.result_slot);
        errors++;
      end else begin
        want = rsp_due.pop_front();
        if (rsp.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
          errors++;
        end
        if (rsp.result_slot !== want.slot) begin
          $display("%0t: result_slot expected %0d actual %0d", $time, want.slot,
                   rsp.result_slot);
          errors++;
        end
        if (rsp.read_value !== want.value) begin
          $display("%0t: read_value expected %h actual %h", $time, want.value,
                   rsp.read_value);
          errors++;
        end
        if (rsp.entry_size !== want.size) begin
          $display("%0t: entry_size expected %0d actual %0d", $time, want.size,
                   rsp.entry_size);
          errors++;
        end
        if (rsp.used_count !== want.used) begin
          $display("%0t: used_count expected %0d actual %0d", $time, want.used,
                   rsp.used_count);
          errors++;
        end
      end
    end
  end

  // Reset, run each test in turn, then drain and report
  initial begin
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.mode       = MODE_PUSH;
    req.slot_index = '0;
    req.push_value = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_partial();
    test_backpressure();
    test_fill_table();
    test_full_churn();
    wait_drain();
    repeat (20) @(negedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Bound the run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
+incdir+design
design/stf_pkg.sv
design/stf_if.sv
design/stf_ram.sv
design/slot_table_with_free_list.sv
bench/tb.sv
